// ----- rtl/rci_pkg.sv -----
// Shared types, constants and saturating helpers for the ray/cone intersection pipeline.
// No dependencies; every rtl file imports this package.
package rci_pkg;

   // Fixed-point format and derived widths
   localparam int FRAC_BITS = 16;
   localparam int MUL_LAT   = 3;
   localparam int SQ_N      = 64 + FRAC_BITS;
   localparam int SQ_P      = (SQ_N + 1) / 2;
   localparam int SQ_NP     = 2 * SQ_P;
   localparam int SQ_RW     = SQ_P + 3;
   localparam int DIV_STEPS = 63;
   localparam int DIV_HW    = FRAC_BITS + 1;

   typedef logic signed [63:0] q_type;

   localparam q_type SAT_MAX = {1'b0, {63{1'b1}}};
   localparam logic signed [64:0] SAT_HI = {2'b00, {63{1'b1}}};
   localparam logic signed [64:0] SAT_LO = -SAT_HI;

   // Register indexes on the configuration port
   localparam logic [2:0] REG_APEX_X = 3'd0;
   localparam logic [2:0] REG_APEX_Y = 3'd1;
   localparam logic [2:0] REG_APEX_Z = 3'd2;
   localparam logic [2:0] REG_AXIS_X = 3'd3;
   localparam logic [2:0] REG_AXIS_Y = 3'd4;
   localparam logic [2:0] REG_AXIS_Z = 3'd5;
   localparam logic [2:0] REG_HEIGHT = 3'd6;
   localparam logic [2:0] REG_SLOPE  = 3'd7;

   typedef struct packed {
      logic  valid;
      logic  miss;
      q_type a;
      q_type b;
      q_type wu;
      q_type du;
   } sq_side_type;

   typedef struct packed {
      logic  valid;
      logic  miss;
      q_type wu;
      q_type du;
   } div_side_type;

   // Saturating add, clamped symmetrically to +-(2^63-1)
   function automatic q_type sadd(input q_type a, input q_type b);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s > SAT_HI)
         return SAT_MAX;
      else if (s < SAT_LO)
         return -SAT_MAX;
      return s[63:0];
   endfunction

   function automatic q_type ssub(input q_type a, input q_type b);
      return sadd(a, -b);
   endfunction

   function automatic logic [63:0] mag(input q_type x);
      return x[63] ? 64'(-x) : 64'(x);
   endfunction

endpackage

// ----- rtl/rci_mulq.sv -----
// Three-stage fixed-point multiplier: 32x32 partial products, sum, shift and saturate.
// Depends on rci_pkg.
module rci_mulq
   import rci_pkg::*;
(
   input  logic  clock,
   input  q_type a,
   input  q_type b,
   output q_type p
);

   logic [63:0]  ma, mb;
   logic [63:0]  part_ff [4];
   logic         neg1_ff, neg2_ff;
   logic [127:0] full_ff;
   q_type        p_ff;
   logic [63:0]  lo;
   logic         over;
   q_type        m_in;

   assign ma = mag(a);
   assign mb = mag(b);

   // Split the magnitudes into 32-bit halves
   always_ff @(posedge clock) begin
      part_ff[0] <= 64'(ma[31:0])  * 64'(mb[31:0]);
      part_ff[1] <= 64'(ma[31:0])  * 64'(mb[63:32]);
      part_ff[2] <= 64'(ma[63:32]) * 64'(mb[31:0]);
      part_ff[3] <= 64'(ma[63:32]) * 64'(mb[63:32]);
      neg1_ff    <= a[63] ^ b[63];
   end

   // Sum partial products into the full 128-bit product
   always_ff @(posedge clock) begin
      full_ff <= 128'(part_ff[0]) + (128'(part_ff[1]) << 32) +
                 (128'(part_ff[2]) << 32) + (128'(part_ff[3]) << 64);
      neg2_ff <= neg1_ff;
   end

   // Drop the fraction, saturate, restore sign
   assign lo   = full_ff[63+FRAC_BITS:FRAC_BITS];
   assign over = (|full_ff[127:64+FRAC_BITS]) || lo[63];
   assign m_in = over ? SAT_MAX : q_type'(lo);

   always_ff @(posedge clock) begin
      p_ff <= neg2_ff ? -m_in : m_in;
   end

   assign p = p_ff;

endmodule

// ----- rtl/rci_sqrt.sv -----
// Pipelined integer square root, one result bit per stage: floor(sqrt(x * 2^FRAC_BITS)).
// Depends on rci_pkg; carries a side-band record alongside the operand.
module rci_sqrt
   import rci_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  q_type           x,
   input  sq_side_type     side_in,
   output logic [SQ_P-1:0] root,
   output sq_side_type     side_out
);

   logic [SQ_NP-1:0] n_ff    [SQ_P+1];
   logic [SQ_RW-1:0] rem_ff  [SQ_P+1];
   logic [SQ_P-1:0]  root_ff [SQ_P+1];
   sq_side_type      side_ff [SQ_P+1];

   always_ff @(posedge clock) begin
      // Load operand
      n_ff[0]    <= SQ_NP'({x, {FRAC_BITS{1'b0}}});
      rem_ff[0]  <= '0;
      root_ff[0] <= '0;
      side_ff[0] <= side_in;
      // Advance one digit pair per stage
      for (int j = 0; j < SQ_P; j++) begin
         logic [SQ_RW-1:0] rem4, trial;
         rem4  = {rem_ff[j][SQ_RW-3:0], n_ff[j][SQ_NP-1:SQ_NP-2]};
         trial = SQ_RW'({root_ff[j], 2'b01});
         if (rem4 >= trial) begin
            rem_ff[j+1]  <= rem4 - trial;
            root_ff[j+1] <= {root_ff[j][SQ_P-2:0], 1'b1};
         end else begin
            rem_ff[j+1]  <= rem4;
            root_ff[j+1] <= {root_ff[j][SQ_P-2:0], 1'b0};
         end
         n_ff[j+1]    <= n_ff[j] << 2;
         side_ff[j+1] <= side_ff[j];
      end
      if (reset) begin
         for (int j = 0; j <= SQ_P; j++)
            side_ff[j].valid <= 1'b0;
      end
   end

   assign root     = root_ff[SQ_P];
   assign side_out = side_ff[SQ_P];

endmodule

// ----- rtl/rci_div.sv -----
// Two-lane pipelined restoring divider sharing one divisor: trunc(num * 2^FRAC_BITS / den).
// Depends on rci_pkg; one quotient bit per stage, saturated result.
module rci_div
   import rci_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  q_type        num0,
   input  q_type        num1,
   input  q_type        den,
   input  div_side_type side_in,
   output q_type        q0,
   output q_type        q1,
   output div_side_type side_out
);

   localparam int NW = 64 + FRAC_BITS;

   logic [63:0]  rem_ff  [2][DIV_STEPS+1];
   logic [62:0]  low_ff  [2][DIV_STEPS+1];
   logic [62:0]  quo_ff  [2][DIV_STEPS+1];
   logic         over_ff [2][DIV_STEPS+1];
   logic         neg_ff  [2][DIV_STEPS+1];
   logic [63:0]  d_ff    [DIV_STEPS+1];
   div_side_type side_ff [DIV_STEPS+2];
   q_type        q_ff    [2];
   logic [63:0]  d_in;
   q_type        num_in  [2];

   assign d_in      = mag(den);
   assign num_in[0] = num0;
   assign num_in[1] = num1;

   always_ff @(posedge clock) begin
      // Front stage: quotient bits at or above bit 63 only flag overflow
      d_ff[0]    <= d_in;
      side_ff[0] <= side_in;
      for (int l = 0; l < 2; l++) begin
         logic [NW-1:0]     nw;
         logic [DIV_HW-1:0] hi;
         nw = {mag(num_in[l]), {FRAC_BITS{1'b0}}};
         hi = nw[63+FRAC_BITS:63];
         rem_ff[l][0]  <= 64'(hi);
         low_ff[l][0]  <= nw[62:0];
         quo_ff[l][0]  <= '0;
         over_ff[l][0] <= 64'(hi) >= d_in;
         neg_ff[l][0]  <= num_in[l][63] ^ den[63];
      end
      // Restoring steps, one quotient bit each
      for (int i = 0; i < DIV_STEPS; i++) begin
         d_ff[i+1]    <= d_ff[i];
         side_ff[i+1] <= side_ff[i];
         for (int l = 0; l < 2; l++) begin
            logic [64:0] r2;
            logic        ge;
            r2 = {rem_ff[l][i], low_ff[l][i][62]};
            ge = r2 >= {1'b0, d_ff[i]};
            rem_ff[l][i+1]  <= ge ? 64'(r2 - {1'b0, d_ff[i]}) : r2[63:0];
            low_ff[l][i+1]  <= low_ff[l][i] << 1;
            quo_ff[l][i+1]  <= {quo_ff[l][i][61:0], ge};
            over_ff[l][i+1] <= over_ff[l][i];
            neg_ff[l][i+1]  <= neg_ff[l][i];
         end
      end
      // Saturate and apply sign
      side_ff[DIV_STEPS+1] <= side_ff[DIV_STEPS];
      for (int l = 0; l < 2; l++) begin
         q_type m;
         m = over_ff[l][DIV_STEPS] ? SAT_MAX : q_type'({1'b0, quo_ff[l][DIV_STEPS]});
         q_ff[l] <= neg_ff[l][DIV_STEPS] ? -m : m;
      end
      if (reset) begin
         for (int i = 0; i <= DIV_STEPS + 1; i++)
            side_ff[i].valid <= 1'b0;
      end
   end

   assign q0       = q_ff[0];
   assign q1       = q_ff[1];
   assign side_out = side_ff[DIV_STEPS+1];

endmodule

// ----- rtl/ray_cone_intersection.sv -----
// Channel  | Ports                                  | Handshake
// ---------+----------------------------------------+-------------------------------
// request  | req_origin_*, req_direction_*          | start high, busy low
// response | rsp_hit, rsp_hit_distance              | rsp_done strobe, one cycle
// config   | csr_psel/penable/pwrite/paddr/pwdata   | APB write, pready always high
//
// A ray can be accepted every cycle; busy stays low. The depth from an accepted ray to
// its result on rsp_done is made up of (at FRAC_BITS = 16): dot products, coefficient
// products, discriminant, a 41-stage square root and a 65-stage divider.
// Reset is synchronous, clears the valid bits and loads the cone register defaults.
// The receiver cannot stall, so the pipeline never holds.
//
// Top level of the ray/cone intersection pipeline; depends on rci_pkg, rci_mulq,
// rci_sqrt and rci_div.
module ray_cone_intersection
   import rci_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_origin_x,
   input  logic signed [31:0] req_origin_y,
   input  logic signed [31:0] req_origin_z,
   input  logic signed [31:0] req_direction_x,
   input  logic signed [31:0] req_direction_y,
   input  logic signed [31:0] req_direction_z,
   output logic               rsp_done,
   output logic               rsp_hit,
   output logic [30:0]        rsp_hit_distance,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [4:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   typedef struct packed {
      logic  valid;
      q_type dd;
      q_type dw;
      q_type ww;
      q_type du;
      q_type wu;
   } dot_type;

   typedef struct packed {
      logic  valid;
      q_type a;
      q_type b;
      q_type c;
      q_type wu;
      q_type du;
   } abc_type;

   typedef struct packed {
      logic  valid;
      logic  miss;
      q_type t0;
      q_type t1;
      q_type wu;
   } rc_type;

   // Configuration registers
   logic signed [31:0] apex_ff [3];
   logic signed [17:0] axis_ff [3];
   logic [30:0]        height_ff;
   logic [31:0]        slope_ff;
   logic               csr_write;
   logic [2:0]         csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         apex_ff[0] <= '0;
         apex_ff[1] <= '0;
         apex_ff[2] <= '0;
         axis_ff[0] <= '0;
         axis_ff[1] <= 18'sd65536;
         axis_ff[2] <= '0;
         height_ff  <= 31'd65536;
         slope_ff   <= 32'd131072;
      end else if (csr_write) begin
         case (csr_index)
            REG_APEX_X: apex_ff[0] <= csr_pwdata;
            REG_APEX_Y: apex_ff[1] <= csr_pwdata;
            REG_APEX_Z: apex_ff[2] <= csr_pwdata;
            REG_AXIS_X: axis_ff[0] <= csr_pwdata[17:0];
            REG_AXIS_Y: axis_ff[1] <= csr_pwdata[17:0];
            REG_AXIS_Z: axis_ff[2] <= csr_pwdata[17:0];
            REG_HEIGHT: height_ff  <= csr_pwdata[30:0];
            REG_SLOPE:  slope_ff   <= csr_pwdata;
            default:    ;
         endcase
      end
   end

   // Register readback, raw bits zero-extended
   always_comb begin
      case (csr_index)
         REG_APEX_X: csr_prdata = apex_ff[0];
         REG_APEX_Y: csr_prdata = apex_ff[1];
         REG_APEX_Z: csr_prdata = apex_ff[2];
         REG_AXIS_X: csr_prdata = 32'({axis_ff[0]});
         REG_AXIS_Y: csr_prdata = 32'({axis_ff[1]});
         REG_AXIS_Z: csr_prdata = 32'({axis_ff[2]});
         REG_HEIGHT: csr_prdata = {1'b0, height_ff};
         REG_SLOPE:  csr_prdata = slope_ff;
         default:    csr_prdata = '0;
      endcase
   end

   // Constants derived from configuration
   q_type k_val, half_h;
   q_type u_val [3];

   assign k_val  = q_type'({32'd0, slope_ff});
   assign half_h = q_type'({34'd0, height_ff[30:1]});
   assign u_val[0] = q_type'(axis_ff[0]);
   assign u_val[1] = q_type'(axis_ff[1]);
   assign u_val[2] = q_type'(axis_ff[2]);

   // Capture the ray, offset the origin by the apex
   logic  accept;
   logic  a_valid_ff;
   q_type w_ff [3];
   q_type d_ff [3];
   q_type org_in [3];
   q_type dir_in [3];

   assign busy      = 1'b0;
   assign accept    = start && !busy;
   assign org_in[0] = q_type'(req_origin_x);
   assign org_in[1] = q_type'(req_origin_y);
   assign org_in[2] = q_type'(req_origin_z);
   assign dir_in[0] = q_type'(req_direction_x);
   assign dir_in[1] = q_type'(req_direction_y);
   assign dir_in[2] = q_type'(req_direction_z);

   always_ff @(posedge clock) begin
      for (int g = 0; g < 3; g++) begin
         w_ff[g] <= org_in[g] - q_type'(apex_ff[g]);
         d_ff[g] <= dir_in[g];
      end
      a_valid_ff <= reset ? 1'b0 : accept;
   end

   // Per-axis products for the five dot products
   q_type pdd [3], pdw [3], pww [3], pdu [3], pwu [3];

   for (genvar g = 0; g < 3; g++) begin : g_axis
      rci_mulq u_dd (.clock(clock), .a(d_ff[g]), .b(d_ff[g]),  .p(pdd[g]));
      rci_mulq u_dw (.clock(clock), .a(d_ff[g]), .b(w_ff[g]),  .p(pdw[g]));
      rci_mulq u_ww (.clock(clock), .a(w_ff[g]), .b(w_ff[g]),  .p(pww[g]));
      rci_mulq u_du (.clock(clock), .a(d_ff[g]), .b(u_val[g]), .p(pdu[g]));
      rci_mulq u_wu (.clock(clock), .a(w_ff[g]), .b(u_val[g]), .p(pwu[g]));
   end

   logic va_ff [MUL_LAT];

   always_ff @(posedge clock) begin
      va_ff[0] <= a_valid_ff;
      for (int i = 1; i < MUL_LAT; i++)
         va_ff[i] <= va_ff[i-1];
      if (reset) begin
         for (int i = 0; i < MUL_LAT; i++)
            va_ff[i] <= 1'b0;
      end
   end

   // Sum the dot products in x, y, z order
   dot_type b_ff, b_in;

   always_comb begin
      b_in.valid = va_ff[MUL_LAT-1];
      b_in.dd    = sadd(sadd(pdd[0], pdd[1]), pdd[2]);
      b_in.dw    = sadd(sadd(pdw[0], pdw[1]), pdw[2]);
      b_in.ww    = sadd(sadd(pww[0], pww[1]), pww[2]);
      b_in.du    = sadd(sadd(pdu[0], pdu[1]), pdu[2]);
      b_in.wu    = sadd(sadd(pwu[0], pwu[1]), pwu[2]);
   end

   always_ff @(posedge clock) begin
      b_ff <= b_in;
      if (reset)
         b_ff.valid <= 1'b0;
   end

   // Scale by the slope factor
   q_type   ka, kb;
   dot_type dl1_ff [MUL_LAT];

   rci_mulq u_ka (.clock(clock), .a(k_val), .b(b_ff.du), .p(ka));
   rci_mulq u_kb (.clock(clock), .a(k_val), .b(b_ff.wu), .p(kb));

   always_ff @(posedge clock) begin
      dl1_ff[0] <= b_ff;
      for (int i = 1; i < MUL_LAT; i++)
         dl1_ff[i] <= dl1_ff[i-1];
      if (reset) begin
         for (int i = 0; i < MUL_LAT; i++)
            dl1_ff[i].valid <= 1'b0;
      end
   end

   // Second-level products k(d.u)^2, k(d.u)(w.u), k(w.u)^2
   q_type   pkdd, pkdw, pkww;
   dot_type dl2_ff [MUL_LAT];

   rci_mulq u_kdd (.clock(clock), .a(ka), .b(dl1_ff[MUL_LAT-1].du), .p(pkdd));
   rci_mulq u_kdw (.clock(clock), .a(ka), .b(dl1_ff[MUL_LAT-1].wu), .p(pkdw));
   rci_mulq u_kww (.clock(clock), .a(kb), .b(dl1_ff[MUL_LAT-1].wu), .p(pkww));

   always_ff @(posedge clock) begin
      dl2_ff[0] <= dl1_ff[MUL_LAT-1];
      for (int i = 1; i < MUL_LAT; i++)
         dl2_ff[i] <= dl2_ff[i-1];
      if (reset) begin
         for (int i = 0; i < MUL_LAT; i++)
            dl2_ff[i].valid <= 1'b0;
      end
   end

   // Quadratic coefficients
   abc_type e_ff, e_in;
   q_type   half_b;

   assign half_b = ssub(pkdw, dl2_ff[MUL_LAT-1].dw);

   always_comb begin
      e_in.valid = dl2_ff[MUL_LAT-1].valid;
      e_in.a     = ssub(dl2_ff[MUL_LAT-1].dd, pkdd);
      e_in.b     = sadd(half_b, half_b);
      e_in.c     = ssub(dl2_ff[MUL_LAT-1].ww, pkww);
      e_in.wu    = dl2_ff[MUL_LAT-1].wu;
      e_in.du    = dl2_ff[MUL_LAT-1].du;
   end

   always_ff @(posedge clock) begin
      e_ff <= e_in;
      if (reset)
         e_ff.valid <= 1'b0;
   end

   // Form 4A
   abc_type f_ff;
   q_type   fa_ff;
   q_type   two_a;

   assign two_a = sadd(e_ff.a, e_ff.a);

   always_ff @(posedge clock) begin
      f_ff  <= e_ff;
      fa_ff <= sadd(two_a, two_a);
      if (reset)
         f_ff.valid <= 1'b0;
   end

   // B^2 and 4AC
   q_type   pbb, pac;
   abc_type dl3_ff [MUL_LAT];

   rci_mulq u_bb (.clock(clock), .a(f_ff.b), .b(f_ff.b), .p(pbb));
   rci_mulq u_ac (.clock(clock), .a(fa_ff),  .b(f_ff.c), .p(pac));

   always_ff @(posedge clock) begin
      dl3_ff[0] <= f_ff;
      for (int i = 1; i < MUL_LAT; i++)
         dl3_ff[i] <= dl3_ff[i-1];
      if (reset) begin
         for (int i = 0; i < MUL_LAT; i++)
            dl3_ff[i].valid <= 1'b0;
      end
   end

   // Discriminant and early miss
   q_type       disc_ff, disc_in;
   sq_side_type g_side_ff, g_side_in;

   assign disc_in = ssub(pbb, pac);

   always_comb begin
      g_side_in.valid = dl3_ff[MUL_LAT-1].valid;
      g_side_in.miss  = (disc_in <= 0) || (dl3_ff[MUL_LAT-1].a == 0);
      g_side_in.a     = dl3_ff[MUL_LAT-1].a;
      g_side_in.b     = dl3_ff[MUL_LAT-1].b;
      g_side_in.wu    = dl3_ff[MUL_LAT-1].wu;
      g_side_in.du    = dl3_ff[MUL_LAT-1].du;
   end

   always_ff @(posedge clock) begin
      disc_ff   <= disc_in;
      g_side_ff <= g_side_in;
      if (reset)
         g_side_ff.valid <= 1'b0;
   end

   // Square root of the discriminant
   logic [SQ_P-1:0] root;
   sq_side_type     sq_side;

   rci_sqrt u_sqrt (
      .clock   (clock),
      .reset   (reset),
      .x       (disc_ff),
      .side_in (g_side_ff),
      .root    (root),
      .side_out(sq_side)
   );

   // Numerators and divisor
   q_type        s_val;
   q_type        num0_ff, num1_ff, den_ff;
   div_side_type h_side_ff, h_side_in;

   assign s_val = q_type'({{(64-SQ_P){1'b0}}, root});

   always_comb begin
      h_side_in.valid = sq_side.valid;
      h_side_in.miss  = sq_side.miss;
      h_side_in.wu    = sq_side.wu;
      h_side_in.du    = sq_side.du;
   end

   always_ff @(posedge clock) begin
      num0_ff   <= ssub(sq_side.b, s_val);
      num1_ff   <= sadd(sq_side.b, s_val);
      den_ff    <= sadd(sq_side.a, sq_side.a);
      h_side_ff <= h_side_in;
      if (reset)
         h_side_ff.valid <= 1'b0;
   end

   // Both roots
   q_type        t0, t1;
   div_side_type d_side;

   rci_div u_div (
      .clock   (clock),
      .reset   (reset),
      .num0    (num0_ff),
      .num1    (num1_ff),
      .den     (den_ff),
      .side_in (h_side_ff),
      .q0      (t0),
      .q1      (t1),
      .side_out(d_side)
   );

   // Axis projection of each root
   q_type  pm0, pm1;
   rc_type dl4_ff [MUL_LAT];
   rc_type rc_in;

   rci_mulq u_m0 (.clock(clock), .a(t0), .b(d_side.du), .p(pm0));
   rci_mulq u_m1 (.clock(clock), .a(t1), .b(d_side.du), .p(pm1));

   always_comb begin
      rc_in.valid = d_side.valid;
      rc_in.miss  = d_side.miss;
      rc_in.t0    = t0;
      rc_in.t1    = t1;
      rc_in.wu    = d_side.wu;
   end

   always_ff @(posedge clock) begin
      dl4_ff[0] <= rc_in;
      for (int i = 1; i < MUL_LAT; i++)
         dl4_ff[i] <= dl4_ff[i-1];
      if (reset) begin
         for (int i = 0; i < MUL_LAT; i++)
            dl4_ff[i].valid <= 1'b0;
      end
   end

   // Check each root against positivity and the height band
   q_type m0, m1;
   logic  ok0_in, ok1_in;
   logic  i_valid_ff, i_miss_ff, ok0_ff, ok1_ff;
   q_type t0_ff, t1_ff;

   assign m0 = sadd(dl4_ff[MUL_LAT-1].wu, pm0);
   assign m1 = sadd(dl4_ff[MUL_LAT-1].wu, pm1);
   assign ok0_in = (dl4_ff[MUL_LAT-1].t0 > 0) && (m0 <= half_h) && (-m0 <= half_h);
   assign ok1_in = (dl4_ff[MUL_LAT-1].t1 > 0) && (m1 <= half_h) && (-m1 <= half_h);

   always_ff @(posedge clock) begin
      i_miss_ff  <= dl4_ff[MUL_LAT-1].miss;
      ok0_ff     <= ok0_in;
      ok1_ff     <= ok1_in;
      t0_ff      <= dl4_ff[MUL_LAT-1].t0;
      t1_ff      <= dl4_ff[MUL_LAT-1].t1;
      i_valid_ff <= reset ? 1'b0 : dl4_ff[MUL_LAT-1].valid;
   end

   // Pick the nearest counting root and drive the response
   logic        hit_in;
   q_type       best;
   logic [30:0] dist_in;
   logic        done_ff, hit_ff;
   logic [30:0] dist_ff;

   assign hit_in = !i_miss_ff && (ok0_ff || ok1_ff);

   always_comb begin
      if (ok0_ff && ok1_ff)
         best = (t1_ff < t0_ff) ? t1_ff : t0_ff;
      else
         best = ok0_ff ? t0_ff : t1_ff;
      if (!hit_in || (|best[62:31]))
         dist_in = '1;
      else
         dist_in = best[30:0];
   end

   always_ff @(posedge clock) begin
      hit_ff  <= hit_in;
      dist_ff <= dist_in;
      done_ff <= reset ? 1'b0 : i_valid_ff;
   end

   assign rsp_done         = done_ff;
   assign rsp_hit          = hit_ff;
   assign rsp_hit_distance = dist_ff;

endmodule
